@@ design/assert_macros.svh @@
// assertion helpers for the files that check their own logic
// every macro expects clk and arst_n to be visible where it is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// trigger in this cycle implies the expression in the next cycle
`define ASSERT_NEXT(label, trig, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (expr)) \
		else $error(msg);

// trigger implies the expression in the same cycle
`define ASSERT_SAME(label, trig, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (expr)) \
		else $error(msg);

`endif

@@ design/ddo_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ddo_pkg
// Types, constants and the arctangent table of the wheel odometry block.
// ---------------------------------------------------------------------------
package ddo_pkg;

	// shared multiply / divide unit geometry
	localparam int unsigned MULA_W = 96;
	localparam int unsigned MULB_W = 32;
	localparam int unsigned PROD_W = 128;
	localparam int unsigned MD_CNT_W = $clog2(MULA_W);
	localparam logic [MD_CNT_W-1:0] MUL_LAST = MD_CNT_W'(MULB_W - 1);
	localparam logic [MD_CNT_W-1:0] DIV_LAST = MD_CNT_W'(MULA_W - 1);

	// field widths
	localparam int unsigned DT_W = 24;
	localparam int unsigned MMPC_W = 25;
	localparam int unsigned HPM_W = 30;
	localparam int unsigned CFG_W = 30;
	localparam int unsigned DIST_W = 57;
	localparam int unsigned POS_W = 48;
	localparam int unsigned ANG_W = 32;
	localparam int unsigned LIN_W = 32;

	// cordic datapath
	localparam int unsigned CX_W = 32;
	localparam int unsigned CZ_W = 34;
	localparam logic signed [CX_W-1:0] CORDIC_GAIN = 32'sd652032874;

	localparam logic [MULB_W-1:0] SPEED_SCALE = 32'd1000000;

	// reset values of the scale registers
	localparam logic [MMPC_W-1:0] MMPC_RESET = 25'd16777;
	localparam logic [HPM_W-1:0] HPM_RESET = 30'd1708913;

	// register indexes
	localparam logic [1:0] CFG_LEFT_MM = 2'd0;
	localparam logic [1:0] CFG_RIGHT_MM = 2'd1;
	localparam logic [1:0] CFG_HEADING = 2'd2;

	typedef enum logic [1:0] {
		MD_MUL = 2'd0,
		MD_DIV = 2'd1
	} md_op_t;

	typedef struct packed {
		logic start;
		md_op_t op;
		logic [MULA_W-1:0] a;
		logic [MULB_W-1:0] b;
	} md_req_t;

	typedef struct packed {
		logic done;
		logic [PROD_W-1:0] res;
	} md_rsp_t;

	// arctangent of 2^-i in binary-angle units
	function automatic logic [29:0] atan_entry(input logic [4:0] i);
		logic [29:0] v;
		case (i)
			5'd0: v = 30'd536870912;
			5'd1: v = 30'd316933406;
			5'd2: v = 30'd167458907;
			5'd3: v = 30'd85004756;
			5'd4: v = 30'd42667331;
			5'd5: v = 30'd21354465;
			5'd6: v = 30'd10679838;
			5'd7: v = 30'd5340245;
			5'd8: v = 30'd2670163;
			5'd9: v = 30'd1335087;
			5'd10: v = 30'd667544;
			5'd11: v = 30'd333772;
			5'd12: v = 30'd166886;
			5'd13: v = 30'd83443;
			5'd14: v = 30'd41722;
			5'd15: v = 30'd20861;
			5'd16: v = 30'd10430;
			5'd17: v = 30'd5215;
			5'd18: v = 30'd2608;
			5'd19: v = 30'd1304;
			5'd20: v = 30'd652;
			5'd21: v = 30'd326;
			5'd22: v = 30'd163;
			5'd23: v = 30'd81;
			5'd24: v = 30'd41;
			5'd25: v = 30'd20;
			5'd26: v = 30'd10;
			5'd27: v = 30'd5;
			5'd28: v = 30'd3;
			5'd29: v = 30'd1;
			5'd30: v = 30'd1;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

endpackage

@@ design/ddo_if.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ddo_if
// Sample and pose channels of the odometry block, valid/ready handshake.
// ---------------------------------------------------------------------------
interface ddo_sample_if;
	logic valid;
	logic ready;
	logic signed [31:0] left_count;
	logic signed [31:0] right_count;
	logic [23:0] elapsed_us;
	logic reset_pose;

	modport source(output valid, left_count, right_count, elapsed_us, reset_pose,
		input ready);
	modport sink(input valid, left_count, right_count, elapsed_us, reset_pose,
		output ready);
endinterface

interface ddo_pose_if;
	logic valid;
	logic ready;
	logic signed [47:0] x_pos;
	logic signed [47:0] y_pos;
	logic [31:0] heading;
	logic signed [31:0] linear_speed;
	logic signed [47:0] angular_speed;

	modport source(output valid, x_pos, y_pos, heading, linear_speed, angular_speed,
		input ready);
	modport sink(input valid, x_pos, y_pos, heading, linear_speed, angular_speed,
		output ready);
endinterface

@@ design/diff_drive_odometry.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// diff_drive_odometry
// Differential-drive wheel odometry: pose and speeds from encoder counts.
// ---------------------------------------------------------------------------
// One sample word at a time. A sample with nonzero elapsed time passes
// through the shared bit-serial multiply/divide unit, which works through
// eight products and two speed quotients in turn, and through the CORDIC,
// which runs one stage per cycle. A sample with zero elapsed time skips
// the arithmetic and goes straight to the output state. The next
// sample word is taken while the previous pose word waits at the output.
`include "assert_macros.svh"

module diff_drive_odometry #(
	parameter int unsigned COUNTER_BITS = 32,
	parameter int unsigned CORDIC_STAGES = 24
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [ddo_pkg::CFG_W-1:0] cfg_data,
	ddo_sample_if.sink sample,
	ddo_pose_if.source pose
);

	localparam int unsigned CB = COUNTER_BITS;
	localparam int unsigned DW = ddo_pkg::DIST_W;
	localparam int unsigned PW = ddo_pkg::POS_W;
	localparam logic signed [PW+3:0] POS_MAX = 52'sh0_7FFF_FFFF_FFFF;
	localparam logic signed [PW+3:0] POS_MIN = -52'sh0_8000_0000_0000;

	typedef enum logic [12:0] {
		S_IDLE    = 13'b0000000000001,
		S_MUL_L   = 13'b0000000000010,
		S_MUL_R   = 13'b0000000000100,
		S_HEAD    = 13'b0000000001000,
		S_CORDIC  = 13'b0000000010000,
		S_MUL_X   = 13'b0000000100000,
		S_MUL_Y   = 13'b0000001000000,
		S_MUL_LIN = 13'b0000010000000,
		S_DIV_LIN = 13'b0000100000000,
		S_MUL_AH  = 13'b0001000000000,
		S_MUL_AS  = 13'b0010000000000,
		S_DIV_ANG = 13'b0100000000000,
		S_OUT     = 13'b1000000000000
	} state_t;

	state_t state_q;
	logic go_q;
	logic ovalid_q;

	logic [ddo_pkg::MMPC_W-1:0] left_mm_q;
	logic [ddo_pkg::MMPC_W-1:0] right_mm_q;
	logic [ddo_pkg::HPM_W-1:0] hpm_q;

	logic [CB-1:0] prev_left_q;
	logic [CB-1:0] prev_right_q;
	logic signed [PW-1:0] pos_x_q;
	logic signed [PW-1:0] pos_y_q;
	logic [ddo_pkg::ANG_W-1:0] angle_q;
	logic signed [ddo_pkg::LIN_W-1:0] lin_q;
	logic signed [PW-1:0] ang_q;

	logic [CB-1:0] cl_q;
	logic [CB-1:0] cr_q;
	logic [ddo_pkg::DT_W-1:0] dt_q;
	logic signed [DW-1:0] dl_q;
	logic signed [DW-1:0] dr_q;
	logic signed [ddo_pkg::CX_W-1:0] c_q;
	logic signed [ddo_pkg::CX_W-1:0] s_q;
	logic [ddo_pkg::PROD_W-1:0] prod_q;

	logic signed [PW-1:0] ox_q;
	logic signed [PW-1:0] oy_q;
	logic [ddo_pkg::ANG_W-1:0] oh_q;
	logic signed [ddo_pkg::LIN_W-1:0] ol_q;
	logic signed [PW-1:0] oa_q;

	logic accept;
	logic [CB-1:0] cur_left;
	logic [CB-1:0] cur_right;
	logic [CB-1:0] mag_cl;
	logic [CB-1:0] mag_cr;
	logic signed [DW:0] dd_w;
	logic signed [DW:0] sum_w;
	logic signed [DW-1:0] dm_w;
	logic [DW-1:0] mag_dm;
	logic [DW:0] mag_dd;
	logic [ddo_pkg::CX_W-1:0] mag_c;
	logic [ddo_pkg::CX_W-1:0] mag_s;
	logic [DW-1:0] wheel_p;
	logic [49:0] step_q;
	logic signed [PW+3:0] step_x;
	logic signed [PW+3:0] step_y;
	logic signed [PW+3:0] sum_x;
	logic signed [PW+3:0] sum_y;
	logic [ddo_pkg::MULA_W-1:0] quot;
	logic [ddo_pkg::MULA_W-1:0] lin_cap;
	logic [ddo_pkg::MULA_W-1:0] ang_cap;
	logic [ddo_pkg::LIN_W-1:0] lin_mag;
	logic [PW-1:0] ang_mag;

	ddo_pkg::md_req_t md_req;
	ddo_pkg::md_rsp_t md_rsp;
	logic cd_start;
	logic cd_done;
	logic signed [ddo_pkg::CX_W-1:0] cd_cos;
	logic signed [ddo_pkg::CX_W-1:0] cd_sin;

	function automatic logic signed [PW-1:0] sat48(input logic signed [PW+3:0] v);
		logic signed [PW-1:0] r;
		if (v > POS_MAX) r = POS_MAX[PW-1:0];
		else if (v < POS_MIN) r = POS_MIN[PW-1:0];
		else r = v[PW-1:0];
		return r;
	endfunction

	ddo_muldiv u_muldiv (
		.clk(clk),
		.arst_n(arst_n),
		.req(md_req),
		.rsp(md_rsp)
	);

	ddo_cordic #(
		.STAGES(CORDIC_STAGES)
	) u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.start(cd_start),
		.angle(angle_q),
		.done(cd_done),
		.cos_out(cd_cos),
		.sin_out(cd_sin)
	);

	// wrap-safe count deltas
	assign accept = sample.valid && sample.ready;
	assign cur_left = sample.left_count[CB-1:0];
	assign cur_right = sample.right_count[CB-1:0];
	assign mag_cl = cl_q[CB-1] ? -cl_q : cl_q;
	assign mag_cr = cr_q[CB-1] ? -cr_q : cr_q;

	// wheel difference and mean distance
	assign dd_w = {dr_q[DW-1], dr_q} - {dl_q[DW-1], dl_q};
	assign sum_w = {dr_q[DW-1], dr_q} + {dl_q[DW-1], dl_q};
	assign dm_w = sum_w[DW:1];
	assign mag_dm = dm_w[DW-1] ? -dm_w : dm_w;
	assign mag_dd = dd_w[DW] ? -dd_w : dd_w;
	assign mag_c = c_q[ddo_pkg::CX_W-1] ? -c_q : c_q;
	assign mag_s = s_q[ddo_pkg::CX_W-1] ? -s_q : s_q;

	// signed product of a wheel, position steps and speed caps
	assign wheel_p = {1'b0, md_rsp.res[DW-2:0]};
	assign step_q = md_rsp.res[87:38];
	assign step_x = (dm_w[DW-1] != c_q[ddo_pkg::CX_W-1]) ? -$signed({2'b0, step_q})
		: $signed({2'b0, step_q});
	assign step_y = (dm_w[DW-1] != s_q[ddo_pkg::CX_W-1]) ? -$signed({2'b0, step_q})
		: $signed({2'b0, step_q});
	assign sum_x = {{4{pos_x_q[PW-1]}}, pos_x_q} + step_x;
	assign sum_y = {{4{pos_y_q[PW-1]}}, pos_y_q} + step_y;
	assign quot = md_rsp.res[ddo_pkg::MULA_W-1:0];
	assign lin_cap = dm_w[DW-1] ? (96'd1 << 31) : ((96'd1 << 31) - 96'd1);
	assign ang_cap = dd_w[DW] ? (96'd1 << 47) : ((96'd1 << 47) - 96'd1);
	assign lin_mag = (quot > lin_cap) ? lin_cap[ddo_pkg::LIN_W-1:0]
		: quot[ddo_pkg::LIN_W-1:0];
	assign ang_mag = (quot > ang_cap) ? ang_cap[PW-1:0] : quot[PW-1:0];

	// operand selection for the shared unit
	always_comb begin
		md_req.start = 1'b0;
		md_req.op = ddo_pkg::MD_MUL;
		md_req.a = '0;
		md_req.b = '0;
		cd_start = 1'b0;
		unique case (state_q)
			S_MUL_L: begin
				md_req.start = go_q;
				md_req.a = {{(ddo_pkg::MULA_W-CB){1'b0}}, mag_cl};
				md_req.b = {7'b0, left_mm_q};
			end
			S_MUL_R: begin
				md_req.start = go_q;
				md_req.a = {{(ddo_pkg::MULA_W-CB){1'b0}}, mag_cr};
				md_req.b = {7'b0, right_mm_q};
			end
			S_HEAD: begin
				md_req.start = go_q;
				md_req.a = {40'b0, dd_w[55:0]};
				md_req.b = {2'b0, hpm_q};
			end
			S_CORDIC: cd_start = go_q;
			S_MUL_X: begin
				md_req.start = go_q;
				md_req.a = {39'b0, mag_dm};
				md_req.b = mag_c;
			end
			S_MUL_Y: begin
				md_req.start = go_q;
				md_req.a = {39'b0, mag_dm};
				md_req.b = mag_s;
			end
			S_MUL_LIN: begin
				md_req.start = go_q;
				md_req.a = {39'b0, mag_dm};
				md_req.b = ddo_pkg::SPEED_SCALE;
			end
			S_DIV_LIN: begin
				md_req.start = go_q;
				md_req.op = ddo_pkg::MD_DIV;
				md_req.a = prod_q[103:8];
				md_req.b = {8'b0, dt_q};
			end
			S_MUL_AH: begin
				md_req.start = go_q;
				md_req.a = {38'b0, mag_dd};
				md_req.b = {2'b0, hpm_q};
			end
			S_MUL_AS: begin
				md_req.start = go_q;
				md_req.a = prod_q[ddo_pkg::MULA_W-1:0];
				md_req.b = ddo_pkg::SPEED_SCALE;
			end
			S_DIV_ANG: begin
				md_req.start = go_q;
				md_req.op = ddo_pkg::MD_DIV;
				md_req.a = prod_q[119:24];
				md_req.b = {8'b0, dt_q};
			end
			default: ;
		endcase
	end

	// sequencer, configuration and odometry state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			go_q <= 1'b0;
			ovalid_q <= 1'b0;
			left_mm_q <= ddo_pkg::MMPC_RESET;
			right_mm_q <= ddo_pkg::MMPC_RESET;
			hpm_q <= ddo_pkg::HPM_RESET;
			prev_left_q <= '0;
			prev_right_q <= '0;
			pos_x_q <= '0;
			pos_y_q <= '0;
			angle_q <= '0;
			lin_q <= '0;
			ang_q <= '0;
		end else begin
			go_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					ddo_pkg::CFG_LEFT_MM: left_mm_q <= cfg_data[ddo_pkg::MMPC_W-1:0];
					ddo_pkg::CFG_RIGHT_MM: right_mm_q <= cfg_data[ddo_pkg::MMPC_W-1:0];
					ddo_pkg::CFG_HEADING: hpm_q <= cfg_data;
					default: ;
				endcase
			end
			if (ovalid_q && pose.ready) ovalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						prev_left_q <= cur_left;
						prev_right_q <= cur_right;
						if (sample.reset_pose) begin
							pos_x_q <= '0;
							pos_y_q <= '0;
							angle_q <= '0;
							ang_q <= '0;
						end
						go_q <= 1'b1;
						state_q <= (sample.elapsed_us == '0) ? S_OUT : S_MUL_L;
					end
				end
				S_MUL_L: if (md_rsp.done) begin
					go_q <= 1'b1;
					state_q <= S_MUL_R;
				end
				S_MUL_R: if (md_rsp.done) begin
					go_q <= 1'b1;
					state_q <= S_HEAD;
				end
				S_HEAD: if (md_rsp.done) begin
					angle_q <= angle_q + md_rsp.res[55:24];
					go_q <= 1'b1;
					state_q <= S_CORDIC;
				end
				S_CORDIC: if (cd_done) begin
					go_q <= 1'b1;
					state_q <= S_MUL_X;
				end
				S_MUL_X: if (md_rsp.done) begin
					pos_x_q <= sat48(sum_x);
					go_q <= 1'b1;
					state_q <= S_MUL_Y;
				end
				S_MUL_Y: if (md_rsp.done) begin
					pos_y_q <= sat48(sum_y);
					go_q <= 1'b1;
					state_q <= S_MUL_LIN;
				end
				S_MUL_LIN: if (md_rsp.done) begin
					go_q <= 1'b1;
					state_q <= S_DIV_LIN;
				end
				S_DIV_LIN: if (md_rsp.done) begin
					lin_q <= dm_w[DW-1] ? -lin_mag : lin_mag;
					go_q <= 1'b1;
					state_q <= S_MUL_AH;
				end
				S_MUL_AH: if (md_rsp.done) begin
					go_q <= 1'b1;
					state_q <= S_MUL_AS;
				end
				S_MUL_AS: if (md_rsp.done) begin
					go_q <= 1'b1;
					state_q <= S_DIV_ANG;
				end
				S_DIV_ANG: if (md_rsp.done) begin
					ang_q <= dd_w[DW] ? -ang_mag : ang_mag;
					state_q <= S_OUT;
				end
				S_OUT: if (!ovalid_q || pose.ready) begin
					ovalid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// per-sample working registers and the output word
	always_ff @(posedge clk) begin
		if (accept) begin
			cl_q <= cur_left - prev_left_q;
			cr_q <= cur_right - prev_right_q;
			dt_q <= sample.elapsed_us;
		end
		if (state_q == S_MUL_L && md_rsp.done) dl_q <= cl_q[CB-1] ? -wheel_p : wheel_p;
		if (state_q == S_MUL_R && md_rsp.done) dr_q <= cr_q[CB-1] ? -wheel_p : wheel_p;
		if (state_q == S_CORDIC && cd_done) begin
			c_q <= cd_cos;
			s_q <= cd_sin;
		end
		if (md_rsp.done) prod_q <= md_rsp.res;
		if (state_q == S_OUT && (!ovalid_q || pose.ready)) begin
			ox_q <= pos_x_q;
			oy_q <= pos_y_q;
			oh_q <= angle_q;
			ol_q <= lin_q;
			oa_q <= ang_q;
		end
	end

	assign sample.ready = (state_q == S_IDLE);
	assign pose.valid = ovalid_q;
	assign pose.x_pos = ox_q;
	assign pose.y_pos = oy_q;
	assign pose.heading = oh_q;
	assign pose.linear_speed = ol_q;
	assign pose.angular_speed = oa_q;

	// checks
	`ASSERT_NEXT(a_zero_dt_skips, accept && sample.elapsed_us == '0, state_q == S_OUT, "zero elapsed time must go straight to output")
	`ASSERT_NEXT(a_heading_hold, !accept && state_q != S_HEAD, $stable(angle_q), "heading moved outside the heading step")
	`ASSERT_SAME(a_word_from_out, $rose(ovalid_q), $past(state_q == S_OUT), "pose word raised outside the output state")

endmodule

@@ design/ddo_muldiv.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ddo_muldiv
// Bit-serial unsigned multiplier (96 x 32) and restoring divider (96 / 24).
// ---------------------------------------------------------------------------
module ddo_muldiv (
	input logic clk,
	input logic arst_n,
	input ddo_pkg::md_req_t req,
	output ddo_pkg::md_rsp_t rsp
);

	logic busy_q;
	logic done_q;
	ddo_pkg::md_op_t op_q;
	logic [ddo_pkg::MD_CNT_W-1:0] cnt_q;
	logic [ddo_pkg::PROD_W-1:0] acc_q;
	logic [ddo_pkg::PROD_W-1:0] a_q;
	logic [ddo_pkg::MULB_W-1:0] b_q;
	logic [ddo_pkg::DT_W-1:0] rem_q;

	logic [ddo_pkg::DT_W:0] trial;
	logic [ddo_pkg::DT_W:0] trial_sub;
	logic trial_ge;
	logic last;

	// one divide step: bring in the next numerator bit and try the subtract
	assign trial = {rem_q, a_q[ddo_pkg::MULA_W-1]};
	assign trial_sub = trial - {1'b0, b_q[ddo_pkg::DT_W-1:0]};
	assign trial_ge = trial >= {1'b0, b_q[ddo_pkg::DT_W-1:0]};
	assign last = (op_q == ddo_pkg::MD_MUL) ? (cnt_q == ddo_pkg::MUL_LAST)
		: (cnt_q == ddo_pkg::DIV_LAST);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
			op_q <= ddo_pkg::MD_MUL;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
				op_q <= req.op;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			a_q <= {{(ddo_pkg::PROD_W-ddo_pkg::MULA_W){1'b0}}, req.a};
			b_q <= req.b;
			rem_q <= '0;
		end else if (busy_q) begin
			a_q <= a_q << 1;
			if (op_q == ddo_pkg::MD_MUL) begin
				if (b_q[0]) acc_q <= acc_q + a_q;
				b_q <= b_q >> 1;
			end else begin
				acc_q <= {acc_q[ddo_pkg::PROD_W-2:0], trial_ge};
				rem_q <= trial_ge ? trial_sub[ddo_pkg::DT_W-1:0]
					: trial[ddo_pkg::DT_W-1:0];
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.res = acc_q;

endmodule

@@ design/ddo_cordic.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ddo_cordic
// Iterative rotation-mode CORDIC, one stage a cycle, for cosine and sine.
// ---------------------------------------------------------------------------
module ddo_cordic #(
	parameter int unsigned STAGES = 24
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [ddo_pkg::ANG_W-1:0] angle,
	output logic done,
	output logic signed [ddo_pkg::CX_W-1:0] cos_out,
	output logic signed [ddo_pkg::CX_W-1:0] sin_out
);

	localparam int unsigned IW = $clog2(STAGES);

	logic busy_q;
	logic done_q;
	logic flip_q;
	logic [IW-1:0] i_q;
	logic signed [ddo_pkg::CX_W-1:0] x_q;
	logic signed [ddo_pkg::CX_W-1:0] y_q;
	logic signed [ddo_pkg::CZ_W-1:0] z_q;

	logic [ddo_pkg::ANG_W-1:0] quarter;
	logic flip_w;
	logic [ddo_pkg::ANG_W-1:0] folded;
	logic signed [ddo_pkg::CX_W-1:0] xs;
	logic signed [ddo_pkg::CX_W-1:0] ys;
	logic signed [ddo_pkg::CZ_W-1:0] at;

	// fold the back half plane by a half turn
	assign quarter = angle + 32'h4000_0000;
	assign flip_w = quarter[ddo_pkg::ANG_W-1];
	assign folded = flip_w ? (angle ^ 32'h8000_0000) : angle;

	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;
	assign at = $signed({4'b0, ddo_pkg::atan_entry(5'(i_q))});

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q <= '0;
			end else if (busy_q) begin
				i_q <= i_q + 1'b1;
				if (i_q == IW'(STAGES - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// rotation stage
	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= ddo_pkg::CORDIC_GAIN;
			y_q <= '0;
			z_q <= $signed({{(ddo_pkg::CZ_W-ddo_pkg::ANG_W){folded[ddo_pkg::ANG_W-1]}},
				folded});
			flip_q <= flip_w;
		end else if (busy_q) begin
			if (!z_q[ddo_pkg::CZ_W-1]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	assign done = done_q;
	assign cos_out = flip_q ? -x_q : x_q;
	assign sin_out = flip_q ? -y_q : y_q;

endmodule

@@ tb/diff_drive_odometry_test.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// diff_drive_odometry_test
// Self-checking bench for the wheel odometry block. An in-bench pose tracker
// predicts every pose word from the sample words the block takes. The bench
// steps through several scale settings, from all zero to full width, and
// mixes directed samples with random ones. Both handshakes see random stalls.
// ---------------------------------------------------------------------------
module diff_drive_odometry_test;

	localparam int unsigned STAGES = 24;
	localparam longint CYCLE_LIMIT = 8000000;
	localparam longint POS_HI = 64'sh7FFFFFFFFFFF;
	localparam longint POS_LO = -64'sh800000000000;

	typedef struct {
		logic [47:0] x_pos;
		logic [47:0] y_pos;
		logic [31:0] heading;
		logic [31:0] linear_speed;
		logic [47:0] angular_speed;
	} pose_word_t;

	// pose tracker and store of pending pose words
	class pose_tracker;
		bit [24:0] left_scale, right_scale;
		bit [29:0] turn_scale;
		bit [31:0] last_left, last_right, angle;
		longint pos_x, pos_y, lin_speed, ang_speed;
		pose_word_t pending[$];
		int unsigned errors;
		int unsigned checked;

		function new();
			left_scale = ddo_pkg::MMPC_RESET;
			right_scale = ddo_pkg::MMPC_RESET;
			turn_scale = ddo_pkg::HPM_RESET;
			last_left = 0;
			last_right = 0;
			angle = 0;
			pos_x = 0;
			pos_y = 0;
			lin_speed = 0;
			ang_speed = 0;
			errors = 0;
			checked = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [29:0] val);
			if (idx == ddo_pkg::CFG_LEFT_MM) left_scale = val[24:0];
			else if (idx == ddo_pkg::CFG_RIGHT_MM) right_scale = val[24:0];
			else if (idx == ddo_pkg::CFG_HEADING) turn_scale = val;
		endfunction

		function bit [63:0] magnitude(longint v);
			return v < 0 ? 64'(-v) : 64'(v);
		endfunction

		function longint pos_step(longint d, longint t);
			bit [127:0] pr;
			bit [63:0] q;
			pr = 128'(magnitude(d)) * 128'(magnitude(t));
			q = pr[101:38];
			return ((d < 0) != (t < 0)) ? -longint'(q) : longint'(q);
		endfunction

		function longint sat48(longint a, longint b);
			longint r;
			r = a + b;
			if (r > POS_HI) return POS_HI;
			if (r < POS_LO) return POS_LO;
			return r;
		endfunction

		function longint rate(longint num, bit [63:0] scale, bit [63:0] den,
				bit [63:0] pmax);
			bit [127:0] pr, q;
			bit [63:0] cap, qq;
			pr = 128'(magnitude(num)) * 128'(scale);
			q = pr / 128'(den);
			cap = num < 0 ? pmax + 1 : pmax;
			qq = (q > 128'(cap)) ? cap : q[63:0];
			return num < 0 ? -longint'(qq) : longint'(qq);
		endfunction

		// fold by pi, then rotate stage by stage
		function void rotate(bit [31:0] a, output longint c, output longint s);
			longint x, y, z, xs, ys;
			bit flip;
			bit [31:0] b, sum;
			x = longint'(ddo_pkg::CORDIC_GAIN);
			y = 0;
			sum = a + 32'h40000000;
			flip = sum[31];
			b = flip ? a - 32'h80000000 : a;
			z = longint'($signed(b));
			for (int i = 0; i < STAGES; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (z >= 0) begin
					x = x - ys;
					y = y + xs;
					z = z - longint'(ddo_pkg::atan_entry(5'(i)));
				end else begin
					x = x + ys;
					y = y - xs;
					z = z + longint'(ddo_pkg::atan_entry(5'(i)));
				end
			end
			c = flip ? -x : x;
			s = flip ? -y : y;
		endfunction

		// advance the pose by one accepted sample word
		function void note_sample(logic [31:0] lc, logic [31:0] rc, logic [23:0] dt,
				logic rp);
			bit [31:0] dlc, drc;
			bit [63:0] turn;
			longint cl, cr, dl, dr, dd, dm, c, s;
			pose_word_t w;
			dlc = lc - last_left;
			drc = rc - last_right;
			last_left = lc;
			last_right = rc;
			cl = longint'($signed(dlc));
			cr = longint'($signed(drc));
			if (rp) begin
				pos_x = 0;
				pos_y = 0;
				angle = 0;
				ang_speed = 0;
			end
			if (dt != 0) begin
				dl = cl * longint'(left_scale);
				dr = cr * longint'(right_scale);
				dd = dr - dl;
				dm = (dl + dr) >>> 1;
				turn = 64'(dd) * 64'(turn_scale);
				angle = angle + turn[55:24];
				rotate(angle, c, s);
				pos_x = sat48(pos_x, pos_step(dm, c));
				pos_y = sat48(pos_y, pos_step(dm, s));
				lin_speed = rate(dm, 64'd1000000, 64'(dt) << 8, 64'h7FFFFFFF);
				ang_speed = rate(dd, 64'(turn_scale) * 64'd1000000, 64'(dt) << 24,
					64'(POS_HI));
			end
			w.x_pos = pos_x[47:0];
			w.y_pos = pos_y[47:0];
			w.heading = angle;
			w.linear_speed = lin_speed[31:0];
			w.angular_speed = ang_speed[47:0];
			pending.push_back(w);
		endfunction

		// compare one pose word with the oldest pending one
		function void check_pose(pose_word_t got);
			pose_word_t e;
			if (pending.size() == 0) begin
				$error("pose word with nothing pending");
				errors++;
				return;
			end
			e = pending.pop_front();
			checked++;
			if (got.x_pos !== e.x_pos) begin
				$error("x_pos expected %0h got %0h", e.x_pos, got.x_pos);
				errors++;
			end
			if (got.y_pos !== e.y_pos) begin
				$error("y_pos expected %0h got %0h", e.y_pos, got.y_pos);
				errors++;
			end
			if (got.heading !== e.heading) begin
				$error("heading expected %0h got %0h", e.heading, got.heading);
				errors++;
			end
			if (got.linear_speed !== e.linear_speed) begin
				$error("linear_speed expected %0h got %0h", e.linear_speed,
					got.linear_speed);
				errors++;
			end
			if (got.angular_speed !== e.angular_speed) begin
				$error("angular_speed expected %0h got %0h", e.angular_speed,
					got.angular_speed);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = ddo_pkg::CFG_LEFT_MM;
	logic [ddo_pkg::CFG_W-1:0] cfg_data = '0;

	ddo_sample_if sample ();
	ddo_pose_if pose ();

	diff_drive_odometry i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.sample(sample.sink),
		.pose(pose.source)
	);

	pose_tracker tracker = new();
	bit stalls_on = 1'b1;
	longint cycles = 0;
	logic [31:0] left_abs = 0, right_abs = 0;
	int unsigned zero_dt_words = 0, pose_resets = 0, sent_words = 0;
	int unsigned rx_hold = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// pose side: check accepted words, stall in bursts
	initial pose.ready = 1'b0;
	always @(posedge clk) begin
		pose_word_t got;
		if (pose.valid && pose.ready) begin
			got.x_pos = pose.x_pos;
			got.y_pos = pose.y_pos;
			got.heading = pose.heading;
			got.linear_speed = pose.linear_speed;
			got.angular_speed = pose.angular_speed;
			tracker.check_pose(got);
		end
		if (rx_hold > 0) begin
			rx_hold <= rx_hold - 1;
			pose.ready <= 1'b0;
		end else if (stalls_on && $urandom_range(0, 3) == 0) begin
			rx_hold <= $urandom_range(0, 5);
			pose.ready <= 1'b0;
		end else begin
			pose.ready <= arst_n;
		end
	end

	// one sample word, with an optional idle burst before it
	task automatic send_sample(logic [31:0] lc, logic [31:0] rc, logic [23:0] dt,
			logic rp);
		if (stalls_on && $urandom_range(0, 3) == 0) begin
			sample.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		sample.valid <= 1'b1;
		sample.left_count <= lc;
		sample.right_count <= rc;
		sample.elapsed_us <= dt;
		sample.reset_pose <= rp;
		do @(posedge clk); while (!sample.ready);
		tracker.note_sample(lc, rc, dt, rp);
		sent_words++;
		if (dt == 0) zero_dt_words++;
		if (rp) pose_resets++;
	endtask

	// drain the block, then write one register
	task automatic write_reg(logic [1:0] idx, logic [ddo_pkg::CFG_W-1:0] val);
		sample.valid <= 1'b0;
		@(posedge clk);
		while (tracker.pending.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.set_reg(idx, val);
	endtask

	task automatic set_scales(logic [24:0] l, logic [24:0] r, logic [29:0] h);
		write_reg(ddo_pkg::CFG_LEFT_MM, ddo_pkg::CFG_W'(l));
		write_reg(ddo_pkg::CFG_RIGHT_MM, ddo_pkg::CFG_W'(r));
		write_reg(ddo_pkg::CFG_HEADING, ddo_pkg::CFG_W'(h));
	endtask

	function automatic logic [31:0] pick_delta();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return 32'($signed($urandom_range(0, 400)) - 200);
			4, 5: return 32'($signed($urandom_range(0, 200000)) - 100000);
			6: return $urandom();
			7: return 32'h80000000 + 32'($signed($urandom_range(0, 8)) - 4);
			default: return 32'($signed($urandom_range(0, 4000)) - 2000);
		endcase
	endfunction

	function automatic logic [23:0] pick_dt();
		case ($urandom_range(0, 9))
			0: return 24'd0;
			1: return 24'd1;
			2: return 24'hFFFFFF;
			3: return 24'($urandom());
			default: return 24'($urandom_range(1, 20000));
		endcase
	endfunction

	// mostly plausible motion: both wheels close, sometimes straight
	task automatic random_samples(int unsigned n);
		logic [31:0] dl, dr;
		for (int unsigned k = 0; k < n; k++) begin
			dl = pick_delta();
			case ($urandom_range(0, 3))
				0: dr = dl;
				1: dr = pick_delta();
				default: dr = dl + 32'($signed($urandom_range(0, 40)) - 20);
			endcase
			left_abs = left_abs + dl;
			right_abs = right_abs + dr;
			if ($urandom_range(0, 30) == 0) left_abs = $urandom();
			if ($urandom_range(0, 30) == 0) right_abs = $urandom();
			send_sample(left_abs, right_abs, pick_dt(), $urandom_range(0, 19) == 0);
		end
	endtask

	initial begin
		sample.valid = 1'b0;
		sample.left_count = '0;
		sample.right_count = '0;
		sample.elapsed_us = '0;
		sample.reset_pose = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, wrap, zero time, pose reset
		send_sample(32'd0, 32'd0, 24'd0, 1'b0);
		send_sample(32'd1000, 32'd1000, 24'd10000, 1'b0);
		send_sample(32'd2000, 32'd2600, 24'd10000, 1'b0);
		send_sample(32'd2500, 32'd2000, 24'd1, 1'b0);
		send_sample(32'h7FFFFFFF, 32'h7FFFFFFF, 24'hFFFFFF, 1'b0);
		send_sample(32'h80000000, 32'h80000000, 24'd100, 1'b0);
		send_sample(32'h7FFFFFF0, 32'h80000010, 24'd100, 1'b0);
		send_sample(32'hFFFFFFFF, 32'h00000000, 24'd0, 1'b0);
		send_sample(32'h00000005, 32'hFFFFFFF0, 24'd50, 1'b0);
		send_sample(32'h00000005, 32'hFFFFFFF0, 24'd50, 1'b1);
		send_sample(32'h00000100, 32'h00000300, 24'd0, 1'b1);
		send_sample(32'h00000200, 32'h00000200, 24'hFFFFFF, 1'b1);
		send_sample(32'hFFFFFFFF, 32'hFFFFFFFF, 24'd1, 1'b0);
		send_sample(32'h55555555, 32'hAAAAAAAA, 24'h555555, 1'b0);
		send_sample(32'hAAAAAAAA, 32'h55555555, 24'hAAAAAA, 1'b0);
		left_abs = 32'hAAAAAAAA;
		right_abs = 32'h55555555;

		// default scales
		random_samples(250);
		// everything zero
		set_scales(25'd0, 25'd0, 30'd0);
		random_samples(150);
		// nominal scales of the field range
		set_scales(25'd16777216, 25'd16777216, 30'd683565276);
		random_samples(250);
		// full register width
		set_scales(25'h1FFFFFF, 25'h1FFFFFF, 30'h3FFFFFFF);
		random_samples(250);
		// uneven wheels
		set_scales(25'd1, 25'h1FFFFFF, 30'd1);
		random_samples(150);
		// random settings
		for (int p = 0; p < 4; p++) begin
			set_scales(25'($urandom()), 25'($urandom()), 30'($urandom()));
			random_samples(150);
		end
		// last part without idling
		stalls_on = 1'b0;
		set_scales(25'd16777, 25'd16900, 30'd1708913);
		random_samples(300);

		sample.valid <= 1'b0;
		@(posedge clk);
		while (tracker.pending.size() != 0) @(posedge clk);
		repeat (600) @(posedge clk);

		$display("covered %0d sample words (%0d with zero time, %0d pose resets)",
			sent_words, zero_dt_words, pose_resets);
		$display("checked %0d pose words over ten scale settings", tracker.checked);
		if (tracker.errors == 0 && tracker.pending.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

@@ files.f @@
+incdir+design
design/ddo_pkg.sv
design/ddo_if.sv
design/ddo_muldiv.sv
design/ddo_cordic.sv
design/diff_drive_odometry.sv
tb/diff_drive_odometry_test.sv
